// ===== design/hfn_pkg.sv =====
package hfn_pkg;

    localparam int HFN_MAX_COLS = 256;
    localparam int HFN_MAX_ROWS = 256;

    // squared slope, sum of squares, normalized magnitude
    localparam int HFN_SQ_W  = 31;
    localparam int HFN_SUM_W = 32;
    localparam int HFN_MAG_W = 15;

    localparam logic HFN_REQ_WRITE = 1'b0;
    localparam logic HFN_REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_GAIN_X      = 2'd2,
        CFG_GAIN_Y      = 2'd3
    } hfn_cfg_idx_t;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] height;
    } hfn_req_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [14:0]        normal_z;
        logic               coord_error;
    } hfn_rsp_t;

endpackage

// ===== design/hfn_height_mem.sv =====
module hfn_height_mem #(
    parameter int DEPTH = hfn_pkg::HFN_MAX_COLS * hfn_pkg::HFN_MAX_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        addr,
    input  logic signed [15:0]   wdata,
    output logic signed [15:0]   rdata
);

    logic signed [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/hfn_root_unit.sv =====
module hfn_root_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [hfn_pkg::HFN_SQ_W-1:0]   sq,
    input  logic [hfn_pkg::HFN_SUM_W-1:0]  sum,
    output logic                           done,
    output logic [hfn_pkg::HFN_MAG_W-1:0]  mag
);

    // mag = round(sqrt(sq) * 16384 / sqrt(sum)), one root bit per cycle
    localparam int QW    = 16;
    localparam int QW1   = QW + 1;
    localparam int RW    = 51;
    localparam int WW    = 48;
    localparam int CNT_W = $clog2(QW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RW-1:0]    e_reg;
    logic [WW-1:0]    w_reg;
    logic [QW-1:0]    q_reg;

    logic [RW-1:0]    trial;
    logic             fits;

    assign trial = RW'({w_reg, 2'b00}) + RW'(sum);
    assign fits  = (e_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // e: scaled remainder, w: sum * partial root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            e_reg <= RW'(sq);
            w_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            e_reg <= (fits ? (e_reg - trial) : e_reg) << 2;
            w_reg <= fits ? ((w_reg << 1) + WW'(sum)) : (w_reg << 1);
            q_reg <= {q_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign mag  = hfn_pkg::HFN_MAG_W'((QW1'(q_reg) + QW1'(1)) >> 1);

endmodule

// ===== design/heightfield_normal_engine.sv =====
// Channel  Signals                                   Dir  Moves
// cfg      cfg_valid cfg_ready cfg_index cfg_data    in   register write
// req      req_valid req_ready req                   in   height write or normal query request
// rsp      rsp_valid rsp_ready rsp                   out  normal for each query request
//
// A height write reaches memory in the cycle it is accepted. A query outside the grid goes
// straight to ST_OUT. A query inside is paced by four reads on the single height memory
// port, a shared 17x17 multiplier for slopes and squares, and the bit-serial root unit run
// three times. After reset the height memory is cleared one entry per cycle; req_ready
// stays low meanwhile; cfg writes are always taken.
// A result waiting in rsp does not stop the next request from being taken.
module heightfield_normal_engine #(
    parameter int MAX_COLS = hfn_pkg::HFN_MAX_COLS,
    parameter int MAX_ROWS = hfn_pkg::HFN_MAX_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_ready,
    input  hfn_pkg::hfn_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output hfn_pkg::hfn_rsp_t rsp
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [8:0] COL_CAP = (MAX_COLS > 511) ? 9'd511 : 9'(MAX_COLS);
    localparam logic [8:0] ROW_CAP = (MAX_ROWS > 511) ? 9'd511 : 9'(MAX_ROWS);

    typedef enum logic [13:0] {
        ST_CLEAR     = 14'b00000000000001,
        ST_IDLE      = 14'b00000000000010,
        ST_RD0       = 14'b00000000000100,
        ST_RD1       = 14'b00000000001000,
        ST_RD2       = 14'b00000000010000,
        ST_RD3       = 14'b00000000100000,
        ST_DIFFY     = 14'b00000001000000,
        ST_MULY      = 14'b00000010000000,
        ST_SLOPEY    = 14'b00000100000000,
        ST_SQY       = 14'b00001000000000,
        ST_SUM       = 14'b00010000000000,
        ST_ROOT_GO   = 14'b00100000000000,
        ST_ROOT_WAIT = 14'b01000000000000,
        ST_OUT       = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } comp_t;

    // Q16.16 product, halved -> Q8.8, round half up, saturate
    function automatic logic signed [15:0] slope_sat(input logic signed [33:0] p);
        logic signed [33:0] q;
        logic signed [24:0] s;
        q = p + 34'sd256;
        s = $signed(q[33:9]);
        if (s > 25'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (s < -25'sd32768)
        begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    state_t state_reg, state_next;
    comp_t  comp_reg;

    logic [8:0]  grid_width_reg, grid_height_reg;
    logic [15:0] gain_x_reg, gain_y_reg;
    logic [8:0]  w_eff, h_eff;

    logic [AW-1:0] clr_reg;

    logic [8:0] req_col9, req_row9;
    logic [8:0] col_reg, row_reg, cl_reg, cr_reg, ru_reg, rd_reg;
    logic       in_grid, req_acc, err_reg;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic signed [15:0] mem_wdata, mem_rdata;
    logic [8:0]    addr_col, addr_row;

    logic signed [15:0] hold_reg;
    logic signed [16:0] diff_reg;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic [hfn_pkg::HFN_SQ_W-1:0]  sx2_reg, sy2_reg, root_sq;
    logic [hfn_pkg::HFN_SUM_W-1:0] s_reg;
    logic [hfn_pkg::HFN_MAG_W-1:0] mx_reg, my_reg, mz_reg, root_mag;
    logic root_done;

    logic              rsp_valid_reg;
    hfn_pkg::hfn_rsp_t rsp_reg, rsp_next;
    logic              out_free;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
            gain_x_reg      <= 16'd256;
            gain_y_reg      <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (hfn_pkg::hfn_cfg_idx_t'(cfg_index))
                hfn_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[8:0];
                hfn_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[8:0];
                hfn_pkg::CFG_GAIN_X:      gain_x_reg      <= cfg_data;
                hfn_pkg::CFG_GAIN_Y:      gain_y_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = (grid_width_reg < 9'd2) ? 9'd2 :
                   (grid_width_reg > COL_CAP) ? COL_CAP : grid_width_reg;
    assign h_eff = (grid_height_reg < 9'd2) ? 9'd2 :
                   (grid_height_reg > ROW_CAP) ? ROW_CAP : grid_height_reg;

    assign req_col9  = {1'b0, req.col};
    assign req_row9  = {1'b0, req.row};
    assign in_grid   = (req_col9 < w_eff) && (req_row9 < h_eff);
    assign req_ready = (state_reg == ST_IDLE);
    assign req_acc   = req_valid && req_ready;

    // height memory
    always_comb
    begin
        case (state_reg)
            ST_RD0:
            begin
                addr_col = cr_reg;
                addr_row = row_reg;
            end
            ST_RD1:
            begin
                addr_col = cl_reg;
                addr_row = row_reg;
            end
            ST_RD2:
            begin
                addr_col = col_reg;
                addr_row = rd_reg;
            end
            ST_RD3:
            begin
                addr_col = col_reg;
                addr_row = ru_reg;
            end
            default:
            begin
                addr_col = req_col9;
                addr_row = req_row9;
            end
        endcase
    end

    assign mem_addr  = (state_reg == ST_CLEAR) ? clr_reg :
                       AW'(32'(addr_row) * MAX_COLS + 32'(addr_col));
    assign mem_we    = (state_reg == ST_CLEAR) ||
                       (req_acc && req.req_type == hfn_pkg::HFN_REQ_WRITE && in_grid);
    assign mem_wdata = (state_reg == ST_CLEAR) ? 16'sd0 : req.height;

    hfn_height_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_acc && req.req_type == hfn_pkg::HFN_REQ_QUERY)
                begin
                    state_next = in_grid ? ST_RD0 : ST_OUT;
                end
            end
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = ST_RD3;
            ST_RD3:    state_next = ST_DIFFY;
            ST_DIFFY:  state_next = ST_MULY;
            ST_MULY:   state_next = ST_SLOPEY;
            ST_SLOPEY: state_next = ST_SQY;
            ST_SQY:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT_GO;
            ST_ROOT_GO: state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    state_next = (comp_reg == COMP_Z) ? ST_OUT : ST_ROOT_GO;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            comp_reg  <= COMP_X;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_SUM)
            begin
                comp_reg <= COMP_X;
            end
            else if (state_reg == ST_ROOT_WAIT && root_done)
            begin
                comp_reg <= (comp_reg == COMP_X) ? COMP_Y : COMP_Z;
            end
        end
    end

    // shared multiplier: two slopes, then two squares
    always_comb
    begin
        case (state_reg)
            ST_MULY:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, gain_y_reg});
            end
            ST_SLOPEY:
            begin
                mul_a = {sx_reg[15], sx_reg};
                mul_b = {sx_reg[15], sx_reg};
            end
            ST_SQY:
            begin
                mul_a = {sy_reg[15], sy_reg};
                mul_b = {sy_reg[15], sy_reg};
            end
            default:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, gain_x_reg});
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (req_acc)
        begin
            col_reg <= req_col9;
            row_reg <= req_row9;
            cl_reg  <= (req_col9 == 9'd0) ? (w_eff - 9'd1) : (req_col9 - 9'd1);
            cr_reg  <= (req_col9 + 9'd1 == w_eff) ? 9'd0 : (req_col9 + 9'd1);
            ru_reg  <= (req_row9 == 9'd0) ? (h_eff - 9'd1) : (req_row9 - 9'd1);
            rd_reg  <= (req_row9 + 9'd1 == h_eff) ? 9'd0 : (req_row9 + 9'd1);
            err_reg <= !in_grid;
        end
        case (state_reg)
            ST_RD1:   hold_reg <= mem_rdata;
            ST_RD2:   diff_reg <= {hold_reg[15], hold_reg} - {mem_rdata[15], mem_rdata};
            ST_RD3:   hold_reg <= mem_rdata;
            ST_DIFFY:
            begin
                diff_reg <= {hold_reg[15], hold_reg} - {mem_rdata[15], mem_rdata};
                sx_reg   <= slope_sat(prod_reg);
            end
            ST_SLOPEY: sy_reg  <= slope_sat(prod_reg);
            ST_SQY:    sx2_reg <= prod_reg[hfn_pkg::HFN_SQ_W-1:0];
            ST_SUM:
            begin
                sy2_reg <= prod_reg[hfn_pkg::HFN_SQ_W-1:0];
                s_reg   <= hfn_pkg::HFN_SUM_W'(sx2_reg)
                         + hfn_pkg::HFN_SUM_W'(prod_reg[hfn_pkg::HFN_SQ_W-1:0])
                         + hfn_pkg::HFN_SUM_W'(65536);
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    case (comp_reg)
                        COMP_X:  mx_reg <= root_mag;
                        COMP_Y:  my_reg <= root_mag;
                        default: mz_reg <= root_mag;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        case (comp_reg)
            COMP_X:  root_sq = sx2_reg;
            COMP_Y:  root_sq = sy2_reg;
            default: root_sq = hfn_pkg::HFN_SQ_W'(65536);
        endcase
    end

    hfn_root_unit u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_ROOT_GO),
        .sq    (root_sq),
        .sum   (s_reg),
        .done  (root_done),
        .mag   (root_mag)
    );

    // response register
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_next = '0;
        rsp_next.coord_error = err_reg;
        if (!err_reg)
        begin
            rsp_next.normal_x = (sx_reg > 16'sd0) ? $signed(16'd0 - {1'b0, mx_reg})
                                                  : $signed({1'b0, mx_reg});
            rsp_next.normal_y = (sy_reg > 16'sd0) ? $signed(16'd0 - {1'b0, my_reg})
                                                  : $signed({1'b0, my_reg});
            rsp_next.normal_z = mz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_mem_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR) ||
                   (req_acc && req.req_type == hfn_pkg::HFN_REQ_WRITE))
        else $error("height write outside clear or write request");

    a_root_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == ST_ROOT_WAIT)
        else $error("root result while sequencer not waiting");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.coord_error |->
            rsp.normal_x == 16'sd0 && rsp.normal_y == 16'sd0 && rsp.normal_z == 15'd0)
        else $error("coordinate error with nonzero normal");

    a_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.coord_error |-> rsp.normal_z != 15'd0)
        else $error("normal z is zero for a valid cell");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 900000;
    localparam int RAND_PER_PHASE = 175;
    localparam int NUM_PHASES    = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    hfn_pkg::hfn_req_t req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    hfn_pkg::hfn_rsp_t rsp;

    // grid_width, grid_height, gain_x, gain_y per random phase
    logic [15:0] phase_cfg [NUM_PHASES][4] = '{
        '{16'd256,  16'd256,  16'd256,  16'd256},
        '{16'd2,    16'd2,    16'hFFFF, 16'hFFFF},
        '{16'h01FF, 16'd300,  16'd0,    16'd0},
        '{16'd0,    16'd1,    16'd1,    16'hFFFF},
        '{16'hFE11, 16'h7E09, 16'd4096, 16'd300},
        '{16'd256,  16'd2,    16'd128,  16'd64},
        '{16'd100,  16'd256,  16'd1000, 16'd20000},
        '{16'd3,    16'd200,  16'hFFFF, 16'd1}
    };

    // block state as predicted
    logic signed [15:0] height_mem [0:hfn_pkg::HFN_MAX_COLS*hfn_pkg::HFN_MAX_ROWS-1];
    logic [8:0]  cur_w  = 9'd256;
    logic [8:0]  cur_h  = 9'd256;
    logic [15:0] cur_gx = 16'd256;
    logic [15:0] cur_gy = 16'd256;

    hfn_pkg::hfn_req_t pending_reqs[$];
    hfn_pkg::hfn_rsp_t normal_expected[$];

    bit req_accepted = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int rdy_run = 0;
    int cycle_cnt = 0;
    int fail_cnt = 0;
    int n_writes = 0;
    int n_queries = 0;
    int n_outside = 0;
    int n_checked = 0;

    heightfield_normal_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned grid_span(logic [8:0] v, int unsigned maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int cell_height(int unsigned c, int unsigned r);
        return int'(height_mem[r * hfn_pkg::HFN_MAX_COLS + c]);
    endfunction

    // Q8.8 slope: round half up, saturate to 16 bits
    function automatic int slope_q88(int diff, logic [15:0] gain);
        longint g;
        longint p;
        g = gain;
        p = longint'(diff) * g + 256;
        p = p >>> 9;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return int'(p);
    endfunction

    // round(|c| * 16384 / sqrt(s2)), ties away from zero
    function automatic int unsigned unit_mag(int c, longint unsigned s2);
        longint unsigned a;
        longint unsigned rhs;
        longint unsigned t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        a = (c < 0) ? longint'(-c) : longint'(c);
        rhs = (a * a) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * longint'(mid) - 1;
            if (t * t * s2 <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] neg_component(int c, longint unsigned s2);
        logic [15:0] m;
        m = 16'(unit_mag(c, s2));
        return (c > 0) ? -m : m;
    endfunction

    function automatic hfn_pkg::hfn_rsp_t normal_at(logic [7:0] c, logic [7:0] r);
        int unsigned w;
        int unsigned h;
        int unsigned cl;
        int unsigned cr;
        int unsigned ru;
        int unsigned rd;
        int sx;
        int sy;
        longint unsigned s2;
        hfn_pkg::hfn_rsp_t o;
        o = '0;
        w = grid_span(cur_w, hfn_pkg::HFN_MAX_COLS);
        h = grid_span(cur_h, hfn_pkg::HFN_MAX_ROWS);
        if (c >= w || r >= h)
        begin
            o.coord_error = 1'b1;
            return o;
        end
        cl = (c == 0) ? w - 1 : c - 1;
        cr = (c + 1 == w) ? 0 : c + 1;
        ru = (r == 0) ? h - 1 : r - 1;
        rd = (r + 1 == h) ? 0 : r + 1;
        sx = slope_q88(cell_height(cr, r) - cell_height(cl, r), cur_gx);
        sy = slope_q88(cell_height(c, rd) - cell_height(c, ru), cur_gy);
        s2 = longint'(sx) * sx + longint'(sy) * sy + 65536;
        o.normal_x = neg_component(sx, s2);
        o.normal_y = neg_component(sy, s2);
        o.normal_z = 15'(unit_mag(256, s2));
        return o;
    endfunction

    // monitor: config, requests, responses
    always @(posedge clk)
    begin
        hfn_pkg::hfn_rsp_t want;
        req_accepted = req_valid && req_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (hfn_pkg::hfn_cfg_idx_t'(cfg_index))
                    hfn_pkg::CFG_GRID_WIDTH:  cur_w = cfg_data[8:0];
                    hfn_pkg::CFG_GRID_HEIGHT: cur_h = cfg_data[8:0];
                    hfn_pkg::CFG_GAIN_X:      cur_gx = cfg_data;
                    hfn_pkg::CFG_GAIN_Y:      cur_gy = cfg_data;
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (normal_expected.size() == 0)
                begin
                    $error("unexpected response: %h", rsp);
                    fail_cnt++;
                end
                else
                begin
                    want = normal_expected.pop_front();
                    n_checked++;
                    if (rsp.normal_x !== want.normal_x)
                    begin
                        $error("normal_x mismatch: expected %0d, actual %0d",
                               want.normal_x, rsp.normal_x);
                        fail_cnt++;
                    end
                    if (rsp.normal_y !== want.normal_y)
                    begin
                        $error("normal_y mismatch: expected %0d, actual %0d",
                               want.normal_y, rsp.normal_y);
                        fail_cnt++;
                    end
                    if (rsp.normal_z !== want.normal_z)
                    begin
                        $error("normal_z mismatch: expected %0d, actual %0d",
                               want.normal_z, rsp.normal_z);
                        fail_cnt++;
                    end
                    if (rsp.coord_error !== want.coord_error)
                    begin
                        $error("coord_error mismatch: expected %0d, actual %0d",
                               want.coord_error, rsp.coord_error);
                        fail_cnt++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (req.req_type == hfn_pkg::HFN_REQ_QUERY)
                begin
                    want = normal_at(req.col, req.row);
                    normal_expected = {normal_expected, want};
                    n_queries++;
                    if (want.coord_error)
                        n_outside++;
                end
                else
                begin
                    n_writes++;
                    if (req.col < grid_span(cur_w, hfn_pkg::HFN_MAX_COLS) &&
                        req.row < grid_span(cur_h, hfn_pkg::HFN_MAX_ROWS))
                        height_mem[req.row * hfn_pkg::HFN_MAX_COLS + req.col] = req.height;
                end
            end
        end
    end

    // request driver: bursts with gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_valid && !req_accepted)
            ;
        else if (gap_left > 0)
        begin
            req_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_reqs.size() > 0)
        begin
            req <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
        end
        else
            req_valid <= 1'b0;
    end

    // response stalls: runs of ready and not ready
    always @(negedge clk)
    begin
        if (rdy_run == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                rsp_ready <= 1'b0;
                rdy_run = $urandom_range(1, 40);
            end
            else
            begin
                rsp_ready <= 1'b1;
                rdy_run = $urandom_range(1, 60);
            end
        end
        else
            rdy_run--;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(hfn_pkg::hfn_cfg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [15:0] w, logic [15:0] h, logic [15:0] gx, logic [15:0] gy);
        write_reg(hfn_pkg::CFG_GRID_WIDTH, w);
        write_reg(hfn_pkg::CFG_GRID_HEIGHT, h);
        write_reg(hfn_pkg::CFG_GAIN_X, gx);
        write_reg(hfn_pkg::CFG_GAIN_Y, gy);
        @(posedge clk);
    endtask

    // sender holds off until every response is back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || normal_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic hfn_pkg::hfn_req_t mk_req(logic t, logic [7:0] c, logic [7:0] r,
                                                 logic [15:0] hv);
        hfn_pkg::hfn_req_t x;
        x.req_type = t;
        x.col = c;
        x.row = r;
        x.height = hv;
        return x;
    endfunction

    task automatic queue_req(hfn_pkg::hfn_req_t x);
        pending_reqs = {pending_reqs, x};
    endtask

    // mostly near the origin or the far edge so neighbors get written
    function automatic logic [7:0] pick_coord(int unsigned span);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 8'($urandom_range(0, ((span < 8) ? span : 8) - 1));
        if (sel < 8)
            return 8'(span - 1 - $urandom_range(0, ((span < 4) ? span : 4) - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int unsigned sw;
        int unsigned sh;
        logic [15:0] hv;
        foreach (height_mem[i])
            height_mem[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: small 4x3 grid, wrap on every edge, extremes, outside cells
        set_grid(16'd4, 16'd3, 16'd256, 16'd256);
        @(posedge clk);
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd0, 8'd0, 16'h7FFF));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd3, 8'd0, 16'h8000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd1, 8'd0, 16'd100));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd0, 8'd1, 16'h8000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd0, 8'd2, 16'h7FFF));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd0, 8'd0, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd3, 8'd0, 16'hFFFF));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd0, 8'd2, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd4, 8'd1, 16'd12345));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd2, 8'd3, 16'd555));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd3, 8'd1, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd4, 8'd0, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd0, 8'd3, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd255, 8'd255, 16'hFFFF));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd2, 8'd2, 16'h0001));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd2, 8'd1, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd1, 8'd1, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_WRITE, 8'd3, 8'd2, 16'hFFFF));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd3, 8'd2, 16'h0000));
        queue_req(mk_req(hfn_pkg::HFN_REQ_QUERY, 8'd1, 8'd0, 16'h8000));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_grid(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            sw = grid_span(phase_cfg[p][0][8:0], hfn_pkg::HFN_MAX_COLS);
            sh = grid_span(phase_cfg[p][1][8:0], hfn_pkg::HFN_MAX_ROWS);
            @(posedge clk);
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    hv = 16'($urandom);
                else
                    hv = 16'(int'($urandom_range(0, 1023)) - 512);
                queue_req(mk_req(($urandom_range(0, 99) < 55) ?
                                 hfn_pkg::HFN_REQ_WRITE : hfn_pkg::HFN_REQ_QUERY,
                                 pick_coord(sw), pick_coord(sh), hv));
            end
            drain();
        end

        if (normal_expected.size() != 0)
        begin
            $error("%0d responses never arrived", normal_expected.size());
            fail_cnt++;
        end
        $display("Covered %0d height writes and %0d normal queries (%0d outside the grid)",
                 n_writes, n_queries, n_outside);
        $display("over %0d grid/gain settings; %0d responses checked, %0d mismatches",
                 NUM_PHASES + 1, n_checked, fail_cnt);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
